@@ rtl/core/sprayer_command_controller_macros.svh @@
// assertion macros for the sprayer command controller
`ifndef SPRAYER_COMMAND_CONTROLLER_MACROS_SVH
`define SPRAYER_COMMAND_CONTROLLER_MACROS_SVH

// plain clocked assertion with reset disable
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that only holds while an output word is shown
`define SCC_ASSERT_OUT(lbl, clk, rst_n, vld, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
    else $error(msg);

`endif

@@ rtl/core/scc_pkg.sv @@
`default_nettype none
package scc_pkg;

  // result actions
  localparam logic [2:0] ActNone  = 3'd0;
  localparam logic [2:0] ActClose = 3'd1;
  localparam logic [2:0] ActOpen  = 3'd2;
  localparam logic [2:0] ActSpray = 3'd3;
  localparam logic [2:0] ActTimed = 3'd4;
  localparam logic [2:0] ActSave  = 3'd5;

  // input word kinds
  localparam logic OpPwm = 1'b0;
  localparam logic OpCmd = 1'b1;

  // parameter indexes
  localparam logic [2:0] ParOpenTime = 3'd0;
  localparam logic [2:0] ParSprayVol = 3'd2;
  localparam logic [2:0] ParCentre   = 3'd3;
  localparam logic [2:0] ParCloseTh  = 3'd4;
  localparam logic [2:0] ParOpenTh   = 3'd5;
  localparam int unsigned NumParams  = 6;

  // classification limits
  localparam logic [16:0] WindowHalf = 17'd1000;
  localparam logic [15:0] PulseLimit = 16'd2100;
  localparam logic [15:0] AuxLow     = 16'd1100;
  localparam logic [15:0] AuxHigh    = 16'd1900;
  localparam int unsigned AuxShift   = 5;

  // command letters
  localparam logic [7:0] ChSpray = 8'h52; // R
  localparam logic [7:0] ChOpen  = 8'h4F; // O
  localparam logic [7:0] ChClose = 8'h43; // C
  localparam logic [7:0] ChTime  = 8'h54; // T
  localparam logic [7:0] ChVol   = 8'h56; // V
  localparam logic [7:0] ChSVol  = 8'h53; // S
  localparam logic [7:0] ChCent  = 8'h4C; // L
  localparam logic [7:0] ChCloTh = 8'h3C; // <
  localparam logic [7:0] ChOpeTh = 8'h3E; // >

endpackage
`default_nettype wire

@@ rtl/core/sprayer_command_controller.sv @@
// a result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per cycle; the result register is the only stage, so
//   in_ready_o drops only while a result is held with out_ready_i low
// reset (rst_ni low, asynchronous): parser waits for a letter, last task is
//   close, all six parameters are zero and no result is pending
`default_nettype none
module sprayer_command_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] period_main_i,
  input  wire logic [15:0] pulse_main_i,
  input  wire logic [15:0] period_aux_i,
  input  wire logic [15:0] pulse_aux_i,
  input  wire logic [7:0]  command_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       action_o,
  output logic [2:0]       param_index_o,
  output logic [15:0]      param_value_o,
  output logic [15:0]      spray_amount_o
);

  // parser codes
  localparam logic [3:0] PsWait = 4'd0;
  localparam logic [3:0] PsTime = 4'd1;
  localparam logic [3:0] PsVol  = 4'd3;
  localparam logic [3:0] PsSVol = 4'd5;
  localparam logic [3:0] PsCent = 4'd7;
  localparam logic [3:0] PsClo  = 4'd9;
  localparam logic [3:0] PsOpe  = 4'd11;
  localparam logic [3:0] PsLast = 4'd12;

  logic [3:0]  ps_q, ps_d;
  logic [1:0]  last_q, last_d;
  logic [15:0] param_q [scc_pkg::NumParams];
  logic [15:0] param_d [scc_pkg::NumParams];
  logic        out_valid_q;
  logic [2:0]  action_q, action_d;
  logic [2:0]  pidx_q, pidx_d;
  logic [15:0] pval_q, pval_d;
  logic [15:0] amount_q, amount_d;
  logic        in_fire;
  logic [2:0]  aux_cls, main_cls;
  logic [3:0]  ps_off;
  logic [2:0]  pk;
  logic [15:0] aux_diff;
  logic [15:0] merged;

  // window and pulse classification
  function automatic logic [2:0] classify(input logic [15:0] period,
                                          input logic [15:0] pulse,
                                          input logic [15:0] centre,
                                          input logic [15:0] close_th,
                                          input logic [15:0] open_th);
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    logic        in_win;
    logic [2:0]  cls;
    lo_sum = {1'b0, period} + scc_pkg::WindowHalf;
    hi_sum = {1'b0, centre} + scc_pkg::WindowHalf;
    in_win = (lo_sum > {1'b0, centre}) && ({1'b0, period} < hi_sum);
    if (!in_win) begin
      cls = scc_pkg::ActNone;
    end else if (pulse > open_th && pulse < scc_pkg::PulseLimit) begin
      cls = scc_pkg::ActOpen;
    end else if (pulse > close_th && pulse < scc_pkg::PulseLimit) begin
      cls = scc_pkg::ActClose;
    end else begin
      cls = scc_pkg::ActSpray;
    end
    return cls;
  endfunction

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign aux_cls  = classify(period_aux_i, pulse_aux_i, param_q[scc_pkg::ParCentre],
                             param_q[scc_pkg::ParCloseTh], param_q[scc_pkg::ParOpenTh]);
  assign main_cls = classify(period_main_i, pulse_main_i, param_q[scc_pkg::ParCentre],
                             param_q[scc_pkg::ParCloseTh], param_q[scc_pkg::ParOpenTh]);
  assign aux_diff = pulse_aux_i - scc_pkg::AuxLow;

  // parameter slot of the current load state
  assign ps_off = ps_q - 4'd1;
  assign pk     = ps_off[3:1];
  assign merged = {param_q[pk][7:0], command_byte_i};

  // next state and result word
  always_comb begin
    ps_d     = ps_q;
    last_d   = last_q;
    param_d  = param_q;
    action_d = scc_pkg::ActNone;
    pidx_d   = 3'd0;
    pval_d   = 16'd0;
    if (opcode_i == scc_pkg::OpPwm) begin
      if (aux_cls != scc_pkg::ActNone && pulse_aux_i >= scc_pkg::AuxLow &&
          pulse_aux_i <= scc_pkg::AuxHigh) begin
        param_d[scc_pkg::ParSprayVol] = aux_diff >> scc_pkg::AuxShift;
      end
      if (main_cls == scc_pkg::ActClose || main_cls == scc_pkg::ActOpen) begin
        if (last_q != main_cls[1:0]) begin
          action_d = main_cls;
        end
      end else if (main_cls == scc_pkg::ActSpray) begin
        action_d = scc_pkg::ActSpray;
      end
      last_d = main_cls[1:0];
    end else if (ps_q == PsWait) begin
      unique case (command_byte_i)
        scc_pkg::ChSpray: action_d = scc_pkg::ActSpray;
        scc_pkg::ChOpen:  action_d = scc_pkg::ActOpen;
        scc_pkg::ChClose: action_d = scc_pkg::ActClose;
        scc_pkg::ChTime:  ps_d = PsTime;
        scc_pkg::ChVol:   ps_d = PsVol;
        scc_pkg::ChSVol:  ps_d = PsSVol;
        scc_pkg::ChCent:  ps_d = PsCent;
        scc_pkg::ChCloTh: ps_d = PsClo;
        scc_pkg::ChOpeTh: ps_d = PsOpe;
        default:          ps_d = PsWait;
      endcase
    end else if (ps_q <= PsLast) begin
      if (!ps_off[0]) begin
        // high byte replaces the whole parameter
        param_d[pk] = {8'd0, command_byte_i};
        ps_d        = ps_q + 4'd1;
      end else begin
        param_d[pk] = merged;
        ps_d        = PsWait;
        action_d    = (pk == scc_pkg::ParOpenTime) ? scc_pkg::ActTimed : scc_pkg::ActSave;
        pidx_d      = pk;
        pval_d      = merged;
      end
    end else begin
      ps_d = PsWait;
    end
    amount_d = (action_d == scc_pkg::ActSpray) ? param_d[scc_pkg::ParSprayVol] : 16'd0;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= PsWait;
      last_q <= scc_pkg::ActClose[1:0];
      for (int i = 0; i < scc_pkg::NumParams; i++) begin
        param_q[i] <= 16'd0;
      end
    end else if (in_fire) begin
      ps_q    <= ps_d;
      last_q  <= last_d;
      param_q <= param_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= action_d;
      pidx_q   <= pidx_d;
      pval_q   <= pval_d;
      amount_q <= amount_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign param_index_o  = pidx_q;
  assign param_value_o  = pval_q;
  assign spray_amount_o = amount_q;

endmodule
`default_nettype wire

@@ rtl/core/scc_checker.sv @@
`default_nettype none
`include "sprayer_command_controller_macros.svh"
module scc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  action_o,
  input wire logic [2:0]  param_index_o,
  input wire logic [15:0] param_value_o,
  input wire logic [15:0] spray_amount_o
);

  // a held word stays until taken
  `SCC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output word dropped")

  // every accepted word gives a result next cycle
  `SCC_ASSERT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o |=> out_valid_o, "result word missing")

  // spray volume only rides with a spray
  `SCC_ASSERT_OUT(a_amount, clk_i, rst_ni, out_valid_o && action_o != scc_pkg::ActSpray, spray_amount_o == 16'd0, "spray amount on non-spray word")

  // valve actions carry no parameter
  `SCC_ASSERT_OUT(a_no_param, clk_i, rst_ni, out_valid_o && action_o != scc_pkg::ActTimed && action_o != scc_pkg::ActSave, param_index_o == 3'd0 && param_value_o == 16'd0, "parameter on valve word")

  // timed open always reports the open time slot
  `SCC_ASSERT_OUT(a_timed_idx, clk_i, rst_ni, out_valid_o && action_o == scc_pkg::ActTimed, param_index_o == scc_pkg::ParOpenTime, "timed open with wrong index")

endmodule

bind sprayer_command_controller scc_checker u_scc_checker (.*);
`default_nettype wire

@@ test/sprayer_command_checker.sv @@
`default_nettype none
module sprayer_command_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        opcode_i,
  input  wire logic [15:0] period_main_i,
  input  wire logic [15:0] pulse_main_i,
  input  wire logic [15:0] period_aux_i,
  input  wire logic [15:0] pulse_aux_i,
  input  wire logic [7:0]  command_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  action_i,
  input  wire logic [2:0]  param_index_i,
  input  wire logic [15:0] param_value_i,
  input  wire logic [15:0] spray_amount_i,
  output int               mismatches_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  // index of the container volume, not named in the package
  localparam logic [2:0] ParVolume = 3'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  index;
    logic [15:0] value;
    logic [15:0] amount;
  } valve_word_t;

  // shadow of the controller state
  logic        loading;
  logic        low_byte_due;
  logic [2:0]  load_sel;
  logic [2:0]  last_class;
  logic [15:0] param_reg [NumParams];

  valve_word_t expected_q [$];
  int mismatch_count = 0;
  int expected_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = expected_count;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: %s differs, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // none, close, open or spray for one pwm measurement
  function automatic logic [2:0] class_of(logic [15:0] period, logic [15:0] pulse);
    int p;
    int c;
    p = period;
    c = param_reg[ParCentre];
    if (p > c - int'(WindowHalf) && p < c + int'(WindowHalf)) begin
      if (pulse > param_reg[ParOpenTh] && pulse < PulseLimit) return ActOpen;
      if (pulse > param_reg[ParCloseTh] && pulse < PulseLimit) return ActClose;
      return ActSpray;
    end
    return ActNone;
  endfunction

  function automatic int param_of_letter(logic [7:0] b);
    case (b)
      ChTime:  return ParOpenTime;
      ChVol:   return ParVolume;
      ChSVol:  return ParSprayVol;
      ChCent:  return ParCentre;
      ChCloTh: return ParCloseTh;
      ChOpeTh: return ParOpenTh;
      default: return -1;
    endcase
  endfunction

  // advance the shadow state by one accepted word and give its result
  function automatic valve_word_t next_valve_word(logic op, logic [15:0] pm, logic [15:0] wm,
                                                  logic [15:0] pa, logic [15:0] wa,
                                                  logic [7:0] b);
    valve_word_t w;
    logic [2:0]  cls;
    int          sel;
    w = '0;
    if (op == OpPwm) begin
      // aux channel reloads the spray volume before the main channel is looked at
      if (class_of(pa, wa) != ActNone && wa >= AuxLow && wa <= AuxHigh)
        param_reg[ParSprayVol] = (wa - AuxLow) >> AuxShift;
      cls = class_of(pm, wm);
      if ((cls == ActClose || cls == ActOpen) && last_class != cls) begin
        w.action = cls;
      end else if (cls == ActSpray) begin
        w.action = ActSpray;
      end
      last_class = cls;
    end else if (!loading) begin
      sel = param_of_letter(b);
      if (b == ChSpray) begin
        w.action = ActSpray;
      end else if (b == ChOpen) begin
        w.action = ActOpen;
      end else if (b == ChClose) begin
        w.action = ActClose;
      end else if (sel >= 0) begin
        loading      = 1'b1;
        low_byte_due = 1'b0;
        load_sel     = sel[2:0];
      end
    end else if (!low_byte_due) begin
      // first byte replaces the whole parameter straight away
      param_reg[load_sel] = {8'h00, b};
      low_byte_due = 1'b1;
    end else begin
      param_reg[load_sel] = {param_reg[load_sel][7:0], b};
      loading  = 1'b0;
      w.action = (load_sel == ParOpenTime) ? ActTimed : ActSave;
      w.index  = load_sel;
      w.value  = param_reg[load_sel];
    end
    if (w.action == ActSpray) w.amount = param_reg[ParSprayVol];
    return w;
  endfunction

  // pop and compare result words, push predictions for input words
  always @(posedge clk_i or negedge rst_ni) begin
    valve_word_t got;
    valve_word_t want;
    if (!rst_ni) begin
      loading      = 1'b0;
      low_byte_due = 1'b0;
      load_sel     = '0;
      last_class   = ActClose;
      for (int i = 0; i < NumParams; i++) param_reg[i] = '0;
      expected_q.delete();
      expected_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{action_i, param_index_i, param_value_i, spray_amount_i};
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing pending, action", got.action, ActNone);
        end else begin
          want = expected_q.pop_front();
          if (got.action !== want.action) report_mismatch("action", got.action, want.action);
          if (got.index !== want.index) report_mismatch("param_index", got.index, want.index);
          if (got.value !== want.value) report_mismatch("param_value", got.value, want.value);
          if (got.amount !== want.amount)
            report_mismatch("spray_amount", got.amount, want.amount);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(next_valve_word(opcode_i, period_main_i, pulse_main_i,
                                             period_aux_i, pulse_aux_i, command_byte_i));
      expected_count = expected_q.size();
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 60;
  localparam int NumWords   = 800;
  localparam int QuietFrom  = 700;
  localparam logic [7:0] ParamLetter [6] = '{ChTime, ChVol, ChSVol, ChCent, ChCloTh, ChOpeTh};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OpPwm;
  logic [15:0] period_main = '0;
  logic [15:0] pulse_main = '0;
  logic [15:0] period_aux = '0;
  logic [15:0] pulse_aux = '0;
  logic [7:0]  command_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  action;
  logic [2:0]  param_index;
  logic [15:0] param_value;
  logic [15:0] spray_amount;

  int mismatches;
  int pending;
  int sent = 0;
  int aim_centre = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_req = 1'b0;

  sprayer_command_controller dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .period_main_i  (period_main),
    .pulse_main_i   (pulse_main),
    .period_aux_i   (period_aux),
    .pulse_aux_i    (pulse_aux),
    .command_byte_i (command_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .action_o       (action),
    .param_index_o  (param_index),
    .param_value_o  (param_value),
    .spray_amount_o (spray_amount)
  );

  sprayer_command_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .period_main_i  (period_main),
    .pulse_main_i   (pulse_main),
    .period_aux_i   (period_aux),
    .pulse_aux_i    (pulse_aux),
    .command_byte_i (command_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .action_i       (action),
    .param_index_i  (param_index),
    .param_value_i  (param_value),
    .spray_amount_i (spray_amount),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // offer one word at a falling edge and hold it until taken
  task automatic offer(logic op, logic [15:0] pm, logic [15:0] wm, logic [15:0] pa,
                       logic [15:0] wa, logic [7:0] b);
    in_valid     <= 1'b1;
    opcode       <= op;
    period_main  <= pm;
    pulse_main   <= wm;
    period_aux   <= pa;
    pulse_aux    <= wa;
    command_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // unused fields carry noise
  task automatic cmd(logic [7:0] b);
    offer(OpCmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  task automatic pwm(logic [15:0] pm, logic [15:0] wm, logic [15:0] pa, logic [15:0] wa);
    offer(OpPwm, pm, wm, pa, wa, 8'($urandom));
  endtask

  // period mostly near the window, now and then anywhere
  function automatic logic [15:0] near_centre();
    int v;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    v = aim_centre - 1100 + int'($urandom_range(0, 2200));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic pwm_random();
    logic [15:0] wm;
    logic [15:0] wa;
    wm = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(800, 2200));
    wa = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1050, 1950));
    pwm(near_centre(), wm, near_centre(), wa);
  endtask

  // receiver: random stalls, and one long hold-off when asked
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("sprayer_command_controller: mismatch");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int          kind;
    int          sel;
    logic [15:0] value;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: thresholds, centre and open time, the valve letters, edges of the window
    cmd(ChCent);  cmd(8'h05); cmd(8'hDC);
    aim_centre = 1500;
    cmd(ChCloTh); cmd(8'h04); cmd(8'hB0);
    cmd(ChOpeTh); cmd(8'h06); cmd(8'h40);
    cmd(ChTime);  cmd(8'hFF); cmd(8'hFF);
    cmd(ChSpray); cmd(ChOpen); cmd(ChClose);
    cmd(8'h00);
    pwm(16'd1500, 16'd1800, 16'd1500, 16'd1900);
    pwm(16'd1500, 16'd1700, 16'd501, 16'd1100);
    pwm(16'd2499, 16'd1300, 16'd500, 16'd1500);
    pwm(16'd1600, 16'hFFFF, 16'd1400, 16'd1899);
    pwm(16'hFFFF, 16'd2100, 16'd1500, 16'd1099);
    pwm(16'd0, 16'd0, 16'd2500, 16'd1500);
    pwm(16'd1500, 16'd2099, 16'd0, 16'd0);

    // random: mostly well-formed loads and measurements
    while (sent < NumWords) begin
      tx_idle_en = (sent < QuietFrom) && ((sent % 200) < 140);
      rx_idle_en = (sent < QuietFrom) && ((sent % 160) >= 30);

      // result register fills while the receiver holds off
      if (!held && sent >= 250) begin
        held       = 1'b1;
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (12) pwm_random();
      end

      // sender waits for every pending result
      if (!paused && sent >= 450) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        sel = $urandom_range(0, 5);
        case (sel)
          ParCentre: begin
            case ($urandom_range(0, 5))
              0:       value = 16'h0000;
              1:       value = 16'hFFFF;
              2:       value = 16'($urandom);
              default: value = 16'($urandom_range(900, 3000));
            endcase
          end
          ParCloseTh, ParOpenTh:
            value = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(800, 2200));
          default: value = 16'($urandom);
        endcase
        cmd(ParamLetter[sel]);
        if ($urandom_range(0, 3) == 0) pwm_random();
        cmd(value[15:8]);
        if ($urandom_range(0, 3) == 0) pwm_random();
        cmd(value[7:0]);
        if (sel == ParCentre) aim_centre = value;
      end else if (kind < 75) begin
        pwm_random();
      end else if (kind < 88) begin
        case ($urandom_range(0, 2))
          0:       cmd(ChSpray);
          1:       cmd(ChOpen);
          default: cmd(ChClose);
        endcase
      end else begin
        cmd(8'($urandom));
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sprayer_command_controller: match");
    end else begin
      $display("sprayer_command_controller: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/sprayer_command_controller.sv
rtl/core/scc_checker.sv
test/sprayer_command_checker.sv
test/tb.sv
